// ===== sv/cpulg_pkg.sv =====
// Package for the CPU limit governor: field widths, reset values of the
// configuration registers, register indexes, FSM state type and serial helpers.
// No dependencies.
`timescale 1ns / 1ps

package cpulg_pkg;

    // Field widths.
    localparam int PROC_W      = 16;
    localparam int OS_W        = 9;
    localparam int RSS_W       = 24;
    localparam int LIM_W       = 16;
    localparam int CORE_W      = 8;
    localparam int VCNT_W      = 8;
    localparam int MEM_W       = 20;

    // Widths of the constant multiples that are compared serially.
    localparam int PROD_W      = CORE_W + OS_W;   // core_count * machine_threshold
    localparam int LIM3_W      = LIM_W + 2;       // limit * 3
    localparam int PROC5_W     = PROC_W + 3;      // process sample * 5
    localparam int OS20_W      = 14;              // machine sample * 20
    localparam int THR19_W     = 14;              // threshold * 19
    localparam int MEM5_W      = MEM_W + 3;       // memory limit * 5

    // Stream and configuration port widths.
    localparam int IN_TDATA_W  = 56;
    localparam int OUT_TDATA_W = 24;
    localparam int CFG_ADDR_W  = 3;
    localparam int CFG_DATA_W  = 20;

    // One serial pass covers the widest operand (the memory sample).
    localparam int PASS_LEN    = 24;
    localparam int CNT_W       = 5;
    localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(PASS_LEN - 1);

    // Configuration reset values.
    localparam logic [LIM_W-1:0]  RST_BASE_LIMIT = 16'd102;
    localparam logic [OS_W-1:0]   RST_THRESHOLD  = 9'd205;
    localparam logic [LIM_W-1:0]  RST_STEP       = 16'd26;
    localparam logic [CORE_W-1:0] RST_CORES      = 8'd1;
    localparam logic [VCNT_W-1:0] RST_CPU_VIOL   = 8'd5;
    localparam logic [MEM_W-1:0]  RST_MEM_LIMIT  = 20'd2048;
    localparam logic [VCNT_W-1:0] RST_MEM_VIOL   = 8'd5;

    // Configuration register indexes.
    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_BASE_LIMIT = 3'd0,
        CFG_THRESHOLD  = 3'd1,
        CFG_STEP       = 3'd2,
        CFG_CORES      = 3'd3,
        CFG_CPU_VIOL   = 3'd4,
        CFG_MEM_LIMIT  = 3'd5,
        CFG_MEM_VIOL   = 3'd6,
        CFG_AUTOSCALE  = 3'd7
    } cfg_idx_t;

    // Sequencer states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_FIN
    } state_t;

    // Borrow out of one bit of a serial subtraction a - b.
    function automatic logic sub_borrow(input logic a, input logic b, input logic bin);
        return (~a & b) | (~(a ^ b) & bin);
    endfunction

endpackage

// ===== sv/cpu_limit_governor_unit.sv =====
// Sequence: a transfer is loaded into the operand registers, a bit-serial pass runs all
// compares, and a commit writes the result into the output register and m_tvalid.
// A new item is taken only after the previous result is committed; the commit state
// waits while the output register still holds a result that m_tready has not taken.
// The serial pass covers 24 bits, sized by the memory sample width.
// Reset (rst_n, async, active low): configuration and governor state to defaults, limit 102, windows zero.
`timescale 1ns / 1ps

module cpu_limit_governor_unit
    import cpulg_pkg::*;
#(
    parameter int WINDOW = 2
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    // Input stream.
    input  logic                    s_tvalid,
    output logic                    s_tready,
    input  logic [IN_TDATA_W-1:0]   s_tdata,   // proc_cpu_usage[15:0], os_cpu_usage[24:16],
                                               // mem_rss_mb[48:25], zero pad[55:49]
    input  logic                    s_tuser,   // check_limits
    // Result stream.
    output logic                    m_tvalid,
    input  logic                    m_tready,
    output logic [OUT_TDATA_W-1:0]  m_tdata,   // scaled_cpu_limit[15:0], cpu_over[16],
                                               // mem_over[17], hard_mem_over[18],
                                               // restart_request[19], zero pad[23:20]
    // Configuration write port.
    input  logic                    cfg_wen,
    input  logic [CFG_ADDR_W-1:0]   cfg_addr,
    input  logic [CFG_DATA_W-1:0]   cfg_wdata
);

    localparam int IDX_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam logic [IDX_W-1:0] LAST_POS = IDX_W'(WINDOW - 1);

    // Configuration registers.
    logic [LIM_W-1:0]  base_reg;
    logic [OS_W-1:0]   thr_reg;
    logic [LIM_W-1:0]  step_reg;
    logic [CORE_W-1:0] cores_reg;
    logic [VCNT_W-1:0] cpu_viol_reg;
    logic [MEM_W-1:0]  mem_lim_reg;
    logic [VCNT_W-1:0] mem_viol_reg;
    logic              auto_reg;

    // Governor state.
    logic [LIM_W-1:0]  lim_reg;
    logic [IDX_W-1:0]  pos_reg;
    logic [VCNT_W-1:0] cpu_cnt_reg;
    logic [VCNT_W-1:0] mem_cnt_reg;

    // Sequencer.
    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              accept;
    logic              commit;
    logic              running;

    // Serial operand shift registers, LSB first.
    logic [LIM_W-1:0]   lim_sh_reg, step_sh_reg, base_sh_reg;
    logic [PROD_W-1:0]  prod_sh_reg;
    logic [PROC_W-1:0]  proc_sh_reg;
    logic [OS_W-1:0]    os_sh_reg, thr_sh_reg;
    logic [RSS_W-1:0]   rss_sh_reg;
    logic [MEM_W-1:0]   mem_sh_reg;
    logic [MEM5_W-1:0]  mem5_sh_reg;
    logic [LIM3_W-1:0]  lim3_sh_reg;
    logic [THR19_W-1:0] thr19_sh_reg;

    // Serial carries and borrows.
    logic b_os_reg, b_d_reg, b_db_reg, c_s_reg, b_sp_reg;
    logic b_pd_reg, b_ps_reg, b_pl_reg, b_pb_reg, b_mr_reg, b_m5r_reg;

    // Captured candidate limits and per-item flags.
    logic [LIM_W-1:0] dcap_reg, scap_reg;
    logic             s_sat_reg;
    logic             check_reg;
    logic             wrap_reg;

    // Output register.
    logic                   m_tvalid_reg;
    logic [OUT_TDATA_W-1:0] m_tdata_reg;

    // Input fields.
    logic [PROC_W-1:0] in_proc;
    logic [OS_W-1:0]   in_os;
    logic [RSS_W-1:0]  in_rss;

    // Current serial bits.
    logic bl, bst, bbs, bpr, bp, bo, bt, br, bm, bm5;
    logic dbit, sbit, c_s_next;

    // Window lanes.
    logic [WINDOW-1:0] lane_ok;
    logic              all_ok;

    // Commit values.
    logic              down, floor_hit, up;
    logic [LIM_W-1:0]  lim_new;
    logic              cpu_cmp;
    logic [VCNT_W-1:0] cpu_cnt_new, mem_cnt_new;
    logic              cpu_over, mem_over, hard_over;

    assign in_proc = s_tdata[15:0];
    assign in_os   = s_tdata[24:16];
    assign in_rss  = s_tdata[48:25];

    assign accept  = s_tvalid && s_tready;
    assign running = (state_reg == ST_RUN);

    // Configuration register writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg     <= RST_BASE_LIMIT;
            thr_reg      <= RST_THRESHOLD;
            step_reg     <= RST_STEP;
            cores_reg    <= RST_CORES;
            cpu_viol_reg <= RST_CPU_VIOL;
            mem_lim_reg  <= RST_MEM_LIMIT;
            mem_viol_reg <= RST_MEM_VIOL;
            auto_reg     <= 1'b0;
        end
        else if (cfg_wen)
        begin
            unique case (cfg_idx_t'(cfg_addr))
                CFG_BASE_LIMIT: base_reg     <= cfg_wdata[LIM_W-1:0];
                CFG_THRESHOLD:  thr_reg      <= cfg_wdata[OS_W-1:0];
                CFG_STEP:       step_reg     <= cfg_wdata[LIM_W-1:0];
                CFG_CORES:      cores_reg    <= cfg_wdata[CORE_W-1:0];
                CFG_CPU_VIOL:   cpu_viol_reg <= cfg_wdata[VCNT_W-1:0];
                CFG_MEM_LIMIT:  mem_lim_reg  <= cfg_wdata[MEM_W-1:0];
                CFG_MEM_VIOL:   mem_viol_reg <= cfg_wdata[VCNT_W-1:0];
                CFG_AUTOSCALE:  auto_reg     <= cfg_wdata[0];
                default:        ;
            endcase
        end
    end

    // Sequencer state register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    // Next state: take an item, run the serial pass, then commit once the
    // output register is free.
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        s_tready   = 1'b0;
        commit     = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    state_next = ST_RUN;
                    cnt_next   = '0;
                end
            end
            ST_RUN:
            begin
                cnt_next = cnt_reg + CNT_W'(1);
                if (cnt_reg == LAST_CNT)
                begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    commit     = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Window write position advances on every autoscaled transfer.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
        end
        else if (accept && auto_reg)
        begin
            pos_reg <= (pos_reg == LAST_POS) ? '0 : pos_reg + IDX_W'(1);
        end
    end

    // Current serial bits and the running difference and sum of limit and step.
    assign bl   = lim_sh_reg[0];
    assign bst  = step_sh_reg[0];
    assign bbs  = base_sh_reg[0];
    assign bpr  = prod_sh_reg[0];
    assign bp   = proc_sh_reg[0];
    assign bo   = os_sh_reg[0];
    assign bt   = thr_sh_reg[0];
    assign br   = rss_sh_reg[0];
    assign bm   = mem_sh_reg[0];
    assign bm5  = mem5_sh_reg[0];
    assign dbit = bl ^ bst ^ b_d_reg;
    assign sbit = bl ^ bst ^ c_s_reg;
    assign c_s_next = (bl & bst) | ((bl ^ bst) & c_s_reg);

    // Operand load on a transfer, one bit per cycle during the pass.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            lim_sh_reg   <= lim_reg;
            step_sh_reg  <= step_reg;
            base_sh_reg  <= base_reg;
            prod_sh_reg  <= PROD_W'(cores_reg) * PROD_W'(thr_reg);
            proc_sh_reg  <= in_proc;
            os_sh_reg    <= in_os;
            thr_sh_reg   <= thr_reg;
            rss_sh_reg   <= in_rss;
            mem_sh_reg   <= mem_lim_reg;
            mem5_sh_reg  <= MEM5_W'({mem_lim_reg, 2'b00}) + MEM5_W'(mem_lim_reg);
            lim3_sh_reg  <= LIM3_W'({lim_reg, 1'b0}) + LIM3_W'(lim_reg);
            thr19_sh_reg <= THR19_W'({thr_reg, 4'b0000}) + THR19_W'({thr_reg, 1'b0})
                            + THR19_W'(thr_reg);
            b_os_reg  <= 1'b0;
            b_d_reg   <= 1'b0;
            b_db_reg  <= 1'b0;
            c_s_reg   <= 1'b0;
            b_sp_reg  <= 1'b0;
            b_pd_reg  <= 1'b0;
            b_ps_reg  <= 1'b0;
            b_pl_reg  <= 1'b0;
            b_pb_reg  <= 1'b0;
            b_mr_reg  <= 1'b0;
            b_m5r_reg <= 1'b0;
            check_reg <= s_tuser;
            wrap_reg  <= auto_reg && (pos_reg == LAST_POS);
        end
        else if (running)
        begin
            lim_sh_reg   <= lim_sh_reg >> 1;
            step_sh_reg  <= step_sh_reg >> 1;
            base_sh_reg  <= base_sh_reg >> 1;
            prod_sh_reg  <= prod_sh_reg >> 1;
            proc_sh_reg  <= proc_sh_reg >> 1;
            os_sh_reg    <= os_sh_reg >> 1;
            thr_sh_reg   <= thr_sh_reg >> 1;
            rss_sh_reg   <= rss_sh_reg >> 1;
            mem_sh_reg   <= mem_sh_reg >> 1;
            mem5_sh_reg  <= mem5_sh_reg >> 1;
            lim3_sh_reg  <= lim3_sh_reg >> 1;
            thr19_sh_reg <= thr19_sh_reg >> 1;
            // Machine usage below threshold.
            b_os_reg  <= sub_borrow(bo, bt, b_os_reg);
            // Limit minus step, and that difference against the base.
            b_d_reg   <= sub_borrow(bl, bst, b_d_reg);
            b_db_reg  <= sub_borrow(dbit, bbs, b_db_reg);
            // Limit plus step, and that sum against cores times threshold.
            c_s_reg   <= c_s_next;
            b_sp_reg  <= sub_borrow(sbit, bpr, b_sp_reg);
            // Process usage above each candidate limit.
            b_pd_reg  <= sub_borrow(dbit, bp, b_pd_reg);
            b_ps_reg  <= sub_borrow(sbit, bp, b_ps_reg);
            b_pl_reg  <= sub_borrow(bl, bp, b_pl_reg);
            b_pb_reg  <= sub_borrow(bbs, bp, b_pb_reg);
            // Memory above the soft and the hard limit.
            b_mr_reg  <= sub_borrow(bm, br, b_mr_reg);
            b_m5r_reg <= sub_borrow(bm5, br, b_m5r_reg);
            // Keep the low bits of the candidate limits and the sum overflow.
            if (cnt_reg < CNT_W'(LIM_W))
            begin
                dcap_reg <= {dbit, dcap_reg[LIM_W-1:1]};
                scap_reg <= {sbit, scap_reg[LIM_W-1:1]};
            end
            if (cnt_reg == CNT_W'(LIM_W))
            begin
                s_sat_reg <= sbit;
            end
        end
    end

    // Window lanes: each entry holds its samples and runs its own two compares.
    genvar gi;
    generate
        for (gi = 0; gi < WINDOW; gi++)
        begin : g_lane
            logic [PROC_W-1:0]  proc_win_reg;
            logic [OS_W-1:0]    os_win_reg;
            logic [PROC5_W-1:0] wp5_sh_reg;
            logic [OS20_W-1:0]  wo20_sh_reg;
            logic               osb_reg;
            logic               pb_reg;
            logic               hit;
            logic [PROC_W-1:0]  eff_proc;
            logic [OS_W-1:0]    eff_os;

            // The current sample replaces this entry when it is the write position.
            assign hit      = auto_reg && (pos_reg == IDX_W'(gi));
            assign eff_proc = hit ? in_proc : proc_win_reg;
            assign eff_os   = hit ? in_os : os_win_reg;

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    proc_win_reg <= '0;
                    os_win_reg   <= '0;
                end
                else if (accept && hit)
                begin
                    proc_win_reg <= in_proc;
                    os_win_reg   <= in_os;
                end
            end

            // Samples times 5 and 20 against limit times 3 and threshold times 19.
            always_ff @(posedge clk)
            begin
                if (accept)
                begin
                    wp5_sh_reg  <= PROC5_W'({eff_proc, 2'b00}) + PROC5_W'(eff_proc);
                    wo20_sh_reg <= OS20_W'({eff_os, 4'b0000}) + OS20_W'({eff_os, 2'b00});
                    osb_reg     <= 1'b0;
                    pb_reg      <= 1'b0;
                end
                else if (running)
                begin
                    wp5_sh_reg  <= wp5_sh_reg >> 1;
                    wo20_sh_reg <= wo20_sh_reg >> 1;
                    osb_reg     <= sub_borrow(wo20_sh_reg[0], thr19_sh_reg[0], osb_reg);
                    pb_reg      <= sub_borrow(wp5_sh_reg[0], lim3_sh_reg[0], pb_reg);
                end
            end

            assign lane_ok[gi] = osb_reg & ~pb_reg;
        end
    endgenerate

    assign all_ok = &lane_ok;

    // Pick the new limit and the CPU compare that goes with it.
    assign down      = ~b_os_reg;
    assign floor_hit = b_d_reg | b_db_reg;
    assign up        = wrap_reg & b_sp_reg & all_ok;

    always_comb
    begin
        lim_new = lim_reg;
        cpu_cmp = b_pb_reg;
        if (auto_reg)
        begin
            cpu_cmp = b_pl_reg;
            if (down)
            begin
                if (floor_hit)
                begin
                    lim_new = base_reg;
                    cpu_cmp = b_pb_reg;
                end
                else
                begin
                    lim_new = dcap_reg;
                    cpu_cmp = b_pd_reg;
                end
            end
            else if (up)
            begin
                lim_new = s_sat_reg ? '1 : scap_reg;
                cpu_cmp = b_ps_reg;
            end
        end
    end

    // Saturating violation counters and the over flags.
    always_comb
    begin
        cpu_cnt_new = cpu_cnt_reg;
        mem_cnt_new = mem_cnt_reg;
        if (check_reg)
        begin
            if (!cpu_cmp)
                cpu_cnt_new = '0;
            else if (cpu_cnt_reg != '1)
                cpu_cnt_new = cpu_cnt_reg + VCNT_W'(1);
            if (!b_mr_reg)
                mem_cnt_new = '0;
            else if (mem_cnt_reg != '1)
                mem_cnt_new = mem_cnt_reg + VCNT_W'(1);
        end
        cpu_over  = check_reg & cpu_cmp & (cpu_cnt_new > cpu_viol_reg);
        mem_over  = check_reg & b_mr_reg & (mem_cnt_new > mem_viol_reg);
        hard_over = check_reg & b_m5r_reg;
    end

    // Governor state commit.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lim_reg     <= RST_BASE_LIMIT;
            cpu_cnt_reg <= '0;
            mem_cnt_reg <= '0;
        end
        else if (commit)
        begin
            lim_reg     <= lim_new;
            cpu_cnt_reg <= cpu_cnt_new;
            mem_cnt_reg <= mem_cnt_new;
        end
    end

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (commit)
        begin
            m_tvalid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (commit)
        begin
            m_tdata_reg <= {4'b0000, cpu_over | mem_over | hard_over, hard_over,
                            mem_over, cpu_over, lim_new};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // The serial pass always ends in the commit state.
    a_pass_end: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RUN && cnt_reg == LAST_CNT) |=> (state_reg == ST_FIN))
        else $error("serial pass did not reach commit");

    // A transfer starts the pass at bit zero.
    a_pass_start: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == ST_RUN && cnt_reg == '0))
        else $error("pass did not start after a transfer");

    // The limit moves only at a commit.
    a_lim_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !commit |=> $stable(lim_reg))
        else $error("limit changed outside a commit");

    // With autoscale off the limit never moves.
    a_lim_fixed: assert property (@(posedge clk) disable iff (!rst_n)
        (commit && !auto_reg) |=> $stable(lim_reg))
        else $error("limit changed with autoscale off");

    // The restart flag is the OR of the three over flags.
    a_restart: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[19] == (m_tdata[16] | m_tdata[17] | m_tdata[18])))
        else $error("restart flag mismatch");

endmodule
